@@ src/mct_pkg.sv @@
package mct_pkg;

  localparam int NumTimersDef = 3;
  localparam int ChannelsDef = 3;

  localparam int OpW = 3;
  localparam int TselW = 2;
  localparam int ChW = 3;
  localparam int DataW = 32;
  localparam int StatusW = 2;
  localparam int ShiftW = 4;
  localparam int ModeW = 2;
  localparam int PcW = 9;
  localparam int CfgAddrW = 2;

  localparam logic [ShiftW-1:0] MaxShift = 4'd9;
  localparam logic [ShiftW-1:0] ShiftReset = 4'd4;
  localparam logic [ModeW-1:0] ModeReset = 2'd3;

  localparam logic [OpW-1:0] OP_TICK = 3'd0;
  localparam logic [OpW-1:0] OP_SET_ABS = 3'd1;
  localparam logic [OpW-1:0] OP_SET_REL = 3'd2;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd3;
  localparam logic [OpW-1:0] OP_READ = 3'd4;
  localparam logic [OpW-1:0] OP_START = 3'd5;
  localparam logic [OpW-1:0] OP_STOP = 3'd6;
  localparam logic [OpW-1:0] OP_RESET_COUNT = 3'd7;

  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_TIMER = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_CHANNEL = 2'd2;

  localparam logic [ModeW-1:0] MODE_16 = 2'd0;
  localparam logic [ModeW-1:0] MODE_8 = 2'd1;
  localparam logic [ModeW-1:0] MODE_24 = 2'd2;

  localparam logic [CfgAddrW-1:0] REG_PRESCALE = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_WIDTH = 2'd1;

  // One accepted request as seen by every timer.
  typedef struct packed {
    logic en;
    logic tick;
    logic set;
    logic rel;
    logic clr;
    logic start;
    logic stop;
    logic zero;
    logic [ChW-1:0] ch;
    logic [DataW-1:0] value;
  } mct_cmd_t;

  function automatic logic [DataW-1:0] width_mask(input logic [ModeW-1:0] mode);
    logic [DataW-1:0] m;
    case (mode)
      MODE_16: m = 32'h0000_FFFF;
      MODE_8:  m = 32'h0000_00FF;
      MODE_24: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ src/mct_timer.sv @@
module mct_timer #(
  parameter int CHANNELS = mct_pkg::ChannelsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mct_pkg::mct_cmd_t           cmd,
  input  logic                        sel,
  input  logic [mct_pkg::ShiftW-1:0]  prescale_shift,
  input  logic [mct_pkg::ModeW-1:0]   width_mode,
  output logic [mct_pkg::DataW-1:0]   count_o,
  output logic [CHANNELS-1:0]         alarm_o
);

  logic [mct_pkg::DataW-1:0] count_r, count_nxt;
  logic [mct_pkg::PcW-1:0]   pc_r, pc_nxt;
  logic                      run_r, run_nxt;
  logic [mct_pkg::DataW-1:0] cmp_r [CHANNELS];
  logic [mct_pkg::DataW-1:0] cmp_nxt [CHANNELS];
  logic [CHANNELS-1:0]       armed_r, armed_nxt;
  logic [CHANNELS-1:0]       evt_r, evt_nxt;

  logic [mct_pkg::DataW-1:0] mask;
  logic [mct_pkg::ShiftW-1:0] sh;
  logic [mct_pkg::PcW:0]     pc_inc;
  logic [mct_pkg::PcW:0]     period;
  logic                      tick_run;
  logic                      adv;
  logic [mct_pkg::DataW-1:0] count_adv;
  logic [mct_pkg::DataW-1:0] set_val;
  logic [CHANNELS-1:0]       hit;

  always_comb begin
    mask = mct_pkg::width_mask(width_mode);
    sh = (prescale_shift > mct_pkg::MaxShift) ? mct_pkg::MaxShift : prescale_shift;
    pc_inc = {1'b0, pc_r} + 10'd1;
    period = 10'd1 << sh;
    tick_run = cmd.en && cmd.tick && run_r;
    adv = tick_run && (pc_inc >= period);
    count_adv = (count_r + 32'd1) & mask;
    set_val = cmd.rel ? ((count_r & mask) + cmd.value - 32'd1) : cmd.value;
    count_o = count_r & mask;

    count_nxt = count_r;
    pc_nxt = pc_r;
    run_nxt = run_r;
    if (tick_run) begin
      if (adv) begin
        pc_nxt = '0;
        count_nxt = count_adv;
      end else begin
        pc_nxt = pc_inc[mct_pkg::PcW-1:0];
      end
    end
    if (cmd.en && sel) begin
      if (cmd.zero) begin
        count_nxt = '0;
        pc_nxt = '0;
      end
      if (cmd.start) run_nxt = 1'b1;
      if (cmd.stop) run_nxt = 1'b0;
    end

    for (int c = 0; c < CHANNELS; c++) begin
      hit[c] = adv && ((cmp_r[c] & mask) == count_adv);
      // An alarm sees the event flag as it stands after this tick's compare.
      alarm_o[c] = cmd.en && cmd.tick && armed_r[c] && (evt_r[c] || hit[c]);
      cmp_nxt[c] = cmp_r[c];
      armed_nxt[c] = armed_r[c];
      evt_nxt[c] = evt_r[c];
      if (alarm_o[c]) begin
        armed_nxt[c] = 1'b0;
        evt_nxt[c] = 1'b0;
      end else if (hit[c]) begin
        evt_nxt[c] = 1'b1;
      end
      if (cmd.en && sel && (cmd.ch == mct_pkg::ChW'(c))) begin
        if (cmd.set) begin
          cmp_nxt[c] = set_val;
          armed_nxt[c] = 1'b1;
          evt_nxt[c] = 1'b0;
        end
        if (cmd.clr) armed_nxt[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pc_r <= '0;
      run_r <= 1'b1;
      armed_r <= '0;
      evt_r <= '0;
      for (int c = 0; c < CHANNELS; c++) cmp_r[c] <= '0;
    end else begin
      count_r <= count_nxt;
      pc_r <= pc_nxt;
      run_r <= run_nxt;
      armed_r <= armed_nxt;
      evt_r <= evt_nxt;
      for (int c = 0; c < CHANNELS; c++) cmp_r[c] <= cmp_nxt[c];
    end
  end

endmodule

@@ src/mct_out.sv @@
module mct_out #(
  parameter int NUM_TIMERS = mct_pkg::NumTimersDef,
  parameter int CHANNELS = mct_pkg::ChannelsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          load_tick,
  input  logic [NUM_TIMERS*CHANNELS-1:0] alarms,
  input  logic [mct_pkg::StatusW-1:0]   ack_status,
  input  logic [mct_pkg::TselW-1:0]     ack_timer,
  input  logic [mct_pkg::ChW-1:0]       ack_channel,
  input  logic [mct_pkg::DataW-1:0]     ack_data,
  output logic                          load_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [mct_pkg::StatusW-1:0]   out_status,
  output logic [mct_pkg::TselW-1:0]     out_timer_id,
  output logic [mct_pkg::ChW-1:0]       out_channel_id,
  output logic [mct_pkg::DataW-1:0]     out_data,
  output logic                          out_last
);

  localparam int NumAlarms = NUM_TIMERS * CHANNELS;

  logic                        ack_v_r, ack_v_nxt;
  logic [NumAlarms-1:0]        alm_r, alm_nxt;
  logic [mct_pkg::StatusW-1:0] st_r;
  logic [mct_pkg::TselW-1:0]   tid_r;
  logic [mct_pkg::ChW-1:0]     cid_r;
  logic [mct_pkg::DataW-1:0]   data_r;

  logic [NumAlarms-1:0]        alm_rest;
  logic [mct_pkg::TselW-1:0]   alm_tid;
  logic [mct_pkg::ChW-1:0]     alm_cid;
  logic                        pending;

  always_comb begin
    alm_rest = alm_r & (alm_r - NumAlarms'(1));
    alm_tid = '0;
    alm_cid = '0;
    // Walk from the highest index down so the lowest pending alarm wins.
    for (int t = NUM_TIMERS - 1; t >= 0; t--) begin
      for (int c = CHANNELS - 1; c >= 0; c--) begin
        if (alm_r[t*CHANNELS+c]) begin
          alm_tid = mct_pkg::TselW'(t);
          alm_cid = mct_pkg::ChW'(c);
        end
      end
    end

    pending = ack_v_r || (|alm_r);
    out_valid = pending;
    out_kind = !ack_v_r;
    out_status = ack_v_r ? st_r : mct_pkg::ST_OK;
    out_timer_id = ack_v_r ? tid_r : alm_tid;
    out_channel_id = ack_v_r ? cid_r : alm_cid;
    out_data = ack_v_r ? data_r : '0;
    out_last = ack_v_r || (alm_rest == '0);
    load_ready = !pending || (out_ready && out_last);

    ack_v_nxt = ack_v_r;
    alm_nxt = alm_r;
    if (out_valid && out_ready) begin
      if (ack_v_r) ack_v_nxt = 1'b0;
      else alm_nxt = alm_rest;
    end
    if (load) begin
      ack_v_nxt = !load_tick;
      alm_nxt = load_tick ? alarms : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_v_r <= 1'b0;
      alm_r <= '0;
    end else begin
      ack_v_r <= ack_v_nxt;
      alm_r <= alm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_r <= ack_status;
      tid_r <= ack_timer;
      cid_r <= ack_channel;
      data_r <= ack_data;
    end
  end

endmodule

@@ src/multi_channel_compare_timer.sv @@
// Compare timer with NUM_TIMERS prescaled counters of CHANNELS one-shot compare
// channels each. Every request is applied to the timer state in the cycle it is
// accepted, so one request enters per clock while results are being taken. A
// non-tick request gives one acknowledgement; a tick gives one alarm result per
// channel that fires, sent in timer-then-channel order one per cycle while
// out_ready is high, and no result if none fires. A tick's alarms hold the input,
// the next request being taken as the last leaves; the result register is the
// only limit on rate. Configuration writes take effect at once.
module multi_channel_compare_timer #(
  parameter int NUM_TIMERS = mct_pkg::NumTimersDef,
  parameter int CHANNELS = mct_pkg::ChannelsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mct_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [mct_pkg::ShiftW-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mct_pkg::OpW-1:0]        in_operation,
  input  logic [mct_pkg::TselW-1:0]      in_timer_select,
  input  logic [mct_pkg::ChW-1:0]        in_channel,
  input  logic [mct_pkg::DataW-1:0]      in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [mct_pkg::StatusW-1:0]    out_status,
  output logic [mct_pkg::TselW-1:0]      out_timer_id,
  output logic [mct_pkg::ChW-1:0]        out_channel_id,
  output logic [mct_pkg::DataW-1:0]      out_data,
  output logic                           out_last
);

  logic [mct_pkg::ShiftW-1:0] prescale_shift_r;
  logic [mct_pkg::ModeW-1:0]  width_mode_r;

  mct_pkg::mct_cmd_t          cmd;
  logic                       accept;
  logic                       uses_ch;
  logic [mct_pkg::StatusW-1:0] status;
  logic [mct_pkg::ChW-1:0]    ch_id;
  logic [mct_pkg::DataW-1:0]  data;
  logic [NUM_TIMERS-1:0]      sel;
  logic [mct_pkg::DataW-1:0]  counts [NUM_TIMERS];
  logic [CHANNELS-1:0]        alarm_w [NUM_TIMERS];
  logic [NUM_TIMERS*CHANNELS-1:0] alarms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_shift_r <= mct_pkg::ShiftReset;
      width_mode_r <= mct_pkg::ModeReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        mct_pkg::REG_PRESCALE: prescale_shift_r <= cfg_wdata;
        mct_pkg::REG_WIDTH:    width_mode_r <= cfg_wdata[mct_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept = in_valid && in_ready;
    uses_ch = (in_operation == mct_pkg::OP_SET_ABS) || (in_operation == mct_pkg::OP_SET_REL)
           || (in_operation == mct_pkg::OP_CLEAR);
    ch_id = uses_ch ? in_channel : '0;
    if (int'(in_timer_select) >= NUM_TIMERS) status = mct_pkg::ST_BAD_TIMER;
    else if (uses_ch && (int'(in_channel) >= CHANNELS)) status = mct_pkg::ST_BAD_CHANNEL;
    else status = mct_pkg::ST_OK;

    data = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      sel[t] = (status == mct_pkg::ST_OK) && (in_timer_select == mct_pkg::TselW'(t));
      if (sel[t] && (in_operation == mct_pkg::OP_READ)) data = counts[t];
      for (int c = 0; c < CHANNELS; c++) alarms[t*CHANNELS+c] = alarm_w[t][c];
    end

    cmd.en = accept;
    cmd.tick = (in_operation == mct_pkg::OP_TICK);
    cmd.set = (in_operation == mct_pkg::OP_SET_ABS) || (in_operation == mct_pkg::OP_SET_REL);
    cmd.rel = (in_operation == mct_pkg::OP_SET_REL);
    cmd.clr = (in_operation == mct_pkg::OP_CLEAR);
    cmd.start = (in_operation == mct_pkg::OP_START);
    cmd.stop = (in_operation == mct_pkg::OP_STOP);
    cmd.zero = (in_operation == mct_pkg::OP_RESET_COUNT);
    cmd.ch = in_channel;
    cmd.value = in_value;
  end

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    mct_timer #(
      .CHANNELS(CHANNELS)
    ) u_timer (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .sel            (sel[t]),
      .prescale_shift (prescale_shift_r),
      .width_mode     (width_mode_r),
      .count_o        (counts[t]),
      .alarm_o        (alarm_w[t])
    );
  end

  mct_out #(
    .NUM_TIMERS(NUM_TIMERS),
    .CHANNELS  (CHANNELS)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .load_tick      (cmd.tick),
    .alarms         (alarms),
    .ack_status     (status),
    .ack_timer      (in_timer_select),
    .ack_channel    (ch_id),
    .ack_data       (data),
    .load_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_timer_id   (out_timer_id),
    .out_channel_id (out_channel_id),
    .out_data       (out_data),
    .out_last       (out_last)
  );

endmodule
